// File: rtl/core/ppou_pkg.sv
// ppou_pkg: shared types and constants of the pixel point operation unit
// no dependencies; used by the top level, the divider stage and the checker
package ppou_pkg;

  localparam int OPERAND_BITS   = 8;
  localparam int MODE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_BIN = 3'd4
  } mode_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OP_MODE = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPERAND = 8'd1;

endpackage

// File: rtl/core/pixel_point_operation_unit.sv
// pixel_point_operation_unit: saturating add/sub/mul, divide, binarize
// top level; uses ppou_pkg and ppou_div_stage
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid / in_ready    | pixel_in
//   out     | output    | out_valid / out_ready  | pixel_out, divide_by_zero
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one beat per clock in and out while out_ready is high; entry register, divider stages, output register
// the restoring divider computes one quotient bit per pipeline stage
// synchronous active-high reset clears valid bits and config registers (mode add, operand 0)
// each stage holds its beat only when the stage after it is full and stalled
// cfg_ready is always high
module pixel_point_operation_unit #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PIXEL_BITS-1:0]               pixel_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [PIXEL_BITS-1:0]               pixel_out,
  output logic                                divide_by_zero,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppou_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppou_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ppou_pkg::*;

  localparam int AW    = PIXEL_BITS + OPERAND_BITS;
  localparam int DEPTH = PIXEL_BITS;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

  logic [MODE_BITS-1:0]    op_mode;
  logic [OPERAND_BITS-1:0] operand;

  // entry stage
  logic                    e_valid;
  logic                    e_ready;
  logic [PIXEL_BITS-1:0]   e_px;
  logic [OPERAND_BITS-1:0] e_op;
  logic [AW-1:0]           e_alt;
  logic                    e_is_div;
  logic                    e_dz;
  logic [AW-1:0]           alt_next;

  // divider chain, index 0 is the entry stage
  logic                    s_valid  [DEPTH+1];
  logic                    s_ready  [1:DEPTH+1];
  logic [PIXEL_BITS-1:0]   s_px     [DEPTH+1];
  logic [PIXEL_BITS-1:0]   s_quo    [DEPTH+1];
  logic [OPERAND_BITS-1:0] s_rem    [DEPTH+1];
  logic [OPERAND_BITS-1:0] s_op     [DEPTH+1];
  logic [AW-1:0]           s_alt    [DEPTH+1];
  logic                    s_is_div [DEPTH+1];
  logic                    s_dz     [DEPTH+1];

  logic                    o_ready;
  logic [PIXEL_BITS-1:0]   sat;
  logic [PIXEL_BITS-1:0]   res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= MODE_ADD;
      operand <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OP_MODE: op_mode <= cfg_data[MODE_BITS-1:0];
        REG_OPERAND: operand <= cfg_data[OPERAND_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (op_mode)
      MODE_ADD: alt_next = AW'(pixel_in) + AW'(operand);
      MODE_SUB: alt_next = (AW'(pixel_in) < AW'(operand)) ? '0
                           : AW'(pixel_in) - AW'(operand);
      MODE_MUL: alt_next = AW'(pixel_in) * AW'(operand);
      MODE_BIN: alt_next = pixel_in[PIXEL_BITS-1] ? AW'(PIX_MAX) : '0;
      default:  alt_next = AW'(pixel_in);
    endcase
  end

  assign e_ready  = !e_valid || s_ready[1];
  assign in_ready = e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && in_valid) begin
      e_px     <= pixel_in;
      e_op     <= operand;
      e_alt    <= alt_next;
      e_is_div <= op_mode == MODE_DIV;
      e_dz     <= (op_mode == MODE_DIV) && (operand == '0);
    end
  end

  assign s_valid[0]  = e_valid;
  assign s_px[0]     = e_px;
  assign s_quo[0]    = '0;
  assign s_rem[0]    = '0;
  assign s_op[0]     = e_op;
  assign s_alt[0]    = e_alt;
  assign s_is_div[0] = e_is_div;
  assign s_dz[0]     = e_dz;

  assign s_ready[DEPTH+1] = o_ready;

  for (genvar k = 1; k <= DEPTH; k++) begin : g_div
    ppou_div_stage #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (s_valid[k-1]),
      .up_ready  (s_ready[k]),
      .up_px     (s_px[k-1]),
      .up_quo    (s_quo[k-1]),
      .up_rem    (s_rem[k-1]),
      .up_op     (s_op[k-1]),
      .up_alt    (s_alt[k-1]),
      .up_is_div (s_is_div[k-1]),
      .up_dz     (s_dz[k-1]),
      .dn_valid  (s_valid[k]),
      .dn_ready  (s_ready[k+1]),
      .dn_px     (s_px[k]),
      .dn_quo    (s_quo[k]),
      .dn_rem    (s_rem[k]),
      .dn_op     (s_op[k]),
      .dn_alt    (s_alt[k]),
      .dn_is_div (s_is_div[k]),
      .dn_dz     (s_dz[k])
    );
  end

  // output stage: saturate and pick the divide result
  always_comb begin
    sat = (s_alt[DEPTH] > AW'(PIX_MAX)) ? PIX_MAX : s_alt[DEPTH][PIXEL_BITS-1:0];
    if (s_is_div[DEPTH]) begin
      res_next = s_dz[DEPTH] ? PIX_MAX : s_quo[DEPTH];
    end else begin
      res_next = sat;
    end
  end

  assign o_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s_valid[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s_valid[DEPTH]) begin
      pixel_out      <= res_next;
      divide_by_zero <= s_dz[DEPTH];
    end
  end

endmodule

// File: rtl/core/ppou_div_stage.sv
// ppou_div_stage: one registered restoring-division step, one quotient bit
// carries the non-divide result alongside; uses ppou_pkg
module ppou_div_stage #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         up_valid,
  output logic                                         up_ready,
  input  logic [PIXEL_BITS-1:0]                        up_px,
  input  logic [PIXEL_BITS-1:0]                        up_quo,
  input  logic [ppou_pkg::OPERAND_BITS-1:0]            up_rem,
  input  logic [ppou_pkg::OPERAND_BITS-1:0]            up_op,
  input  logic [PIXEL_BITS+ppou_pkg::OPERAND_BITS-1:0] up_alt,
  input  logic                                         up_is_div,
  input  logic                                         up_dz,
  output logic                                         dn_valid,
  input  logic                                         dn_ready,
  output logic [PIXEL_BITS-1:0]                        dn_px,
  output logic [PIXEL_BITS-1:0]                        dn_quo,
  output logic [ppou_pkg::OPERAND_BITS-1:0]            dn_rem,
  output logic [ppou_pkg::OPERAND_BITS-1:0]            dn_op,
  output logic [PIXEL_BITS+ppou_pkg::OPERAND_BITS-1:0] dn_alt,
  output logic                                         dn_is_div,
  output logic                                         dn_dz
);
  import ppou_pkg::*;

  logic [OPERAND_BITS:0]   part;
  logic [OPERAND_BITS:0]   part_sub;
  logic                    ge;
  logic [OPERAND_BITS-1:0] rem_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    part     = {up_rem, up_px[PIXEL_BITS-1]};
    part_sub = part - {1'b0, up_op};
    ge       = part >= {1'b0, up_op};
    rem_next = ge ? part_sub[OPERAND_BITS-1:0] : part[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_px     <= {up_px[PIXEL_BITS-2:0], 1'b0};
      dn_quo    <= {up_quo[PIXEL_BITS-2:0], ge};
      dn_rem    <= rem_next;
      dn_op     <= up_op;
      dn_alt    <= up_alt;
      dn_is_div <= up_is_div;
      dn_dz     <= up_dz;
    end
  end

endmodule

// File: rtl/core/ppou_checker.sv
// ppou_checker: port-level assertions for pixel_point_operation_unit
// uses ppou_pkg; bound to the top level below
module ppou_checker #(
  parameter int PIXEL_BITS = 8
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [PIXEL_BITS-1:0]               pixel_in,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [PIXEL_BITS-1:0]               pixel_out,
  input logic                                divide_by_zero,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [ppou_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [ppou_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ppou_pkg::*;

  logic [PIXEL_BITS-1:0] pix_ones;
  logic                  unused_ok;

  assign pix_ones  = '1;
  assign unused_ok = in_valid ^ (^pixel_in) ^ (^cfg_index) ^ (^cfg_data);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(divide_by_zero))
    else $error("output beat changed while stalled");

  // divide by zero forces full scale
  a_dz_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> pixel_out == pix_ones)
    else $error("divide by zero without full-scale pixel");

  // an empty output register means the whole pipeline can take a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid right after reset");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid || unused_ok || !unused_ok |-> cfg_ready)
    else $error("config port stalled");

endmodule

bind pixel_point_operation_unit ppou_checker #(.PIXEL_BITS(PIXEL_BITS)) u_ppou_checker (.*);
